// ===== hdl/xtb_pkg.sv =====
package xtb_pkg;

    localparam int unsigned WORD_W = 32;

    // Round constant, positive form (adding it equals subtracting 0x61C88647)
    localparam logic [WORD_W-1:0] DELTA_NEG = 32'h61C8_8647;
    localparam logic [WORD_W-1:0] DELTA_POS = 32'h9E37_79B9;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [1:0] REG_KEY_WORD3 = 2'd3;

    localparam int unsigned KEY_WORDS = 4;

    // Action codes
    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_key [KEY_WORDS];

    // One pipeline slot. For decryption the two words travel swapped, so that
    // even stages always update word a and odd stages always update word b.
    typedef struct packed {
        logic  valid;
        logic  dec;
        t_word a;
        t_word b;
    } t_stage;

    typedef struct packed {
        t_word left;
        t_word right;
    } t_block;

    function automatic t_word mix(input t_word v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

// ===== hdl/xtb_ifs.sv =====
interface xtb_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] block_left;
    logic [31:0] block_right;

    modport source (output valid, action, block_left, block_right, input ready);
    modport sink   (input valid, action, block_left, block_right, output ready);
endinterface

interface xtb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_left;
    logic [31:0] out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink   (input valid, out_left, out_right, output ready);
endinterface

// ===== hdl/xtea_block_cipher.sv =====
// XTEA block cipher, ECB, 64-bit block, 128-bit key.
// Input channel in_ch: one word = action (0 encrypt, 1 decrypt) plus the
// two 32-bit block words. Output channel out_ch: one word per input word,
// in order, carrying the transformed block words.
// Key: four 32-bit words written through i_cfg_wen / i_cfg_idx / i_cfg_wdata,
// index 0..3 = key word 0..3. Write the key only while no word is in flight.
// Datapath: 2*CYCLE_COUNT register stages, one Feistel half-round each (two
// 32-bit adds deep). Encrypt and decrypt share the stages; the per-stage sum
// is a constant chosen by the action bit.
// Path: an accepted word passes the 2*CYCLE_COUNT stage registers, then the
// output buffer. Throughput: one word per cycle while the buffer has room.
// Stall: a 2-entry output buffer sits after the last stage. The pipeline
// advances as a whole while the buffer has room, so input keeps flowing
// until two finished words wait in the buffer; then in_ch.ready drops.
// in_ch.ready depends only on registers, never combinationally on out_ch.ready.
// Reset: clears all stage valids, the buffer and the key words.
module xtea_block_cipher #(
    parameter int unsigned CYCLE_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    xtb_in_if.sink      in_ch,
    xtb_out_if.source   out_ch
);

    localparam int unsigned STAGES = 2 * CYCLE_COUNT;

    xtb_pkg::t_key   r_key;
    xtb_pkg::t_stage w_stage [STAGES+1];
    xtb_pkg::t_block w_res;
    xtb_pkg::t_block w_out;
    logic            w_en;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < xtb_pkg::KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                xtb_pkg::REG_KEY_WORD0: r_key[0] <= i_cfg_wdata;
                xtb_pkg::REG_KEY_WORD1: r_key[1] <= i_cfg_wdata;
                xtb_pkg::REG_KEY_WORD2: r_key[2] <= i_cfg_wdata;
                xtb_pkg::REG_KEY_WORD3: r_key[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = w_en;

    // Decrypt starts with v1, so the words enter swapped
    always_comb begin
        w_stage[0].valid = in_ch.valid && w_en;
        w_stage[0].dec   = (in_ch.action == xtb_pkg::ACT_DECRYPT);
        w_stage[0].a     = w_stage[0].dec ? in_ch.block_right : in_ch.block_left;
        w_stage[0].b     = w_stage[0].dec ? in_ch.block_left  : in_ch.block_right;
    end

    // Cycle j: even stage updates v0 (enc) / v1 (dec); odd stage the other word
    for (genvar j = 0; j < CYCLE_COUNT; j++) begin : g_cycle
        localparam logic [31:0] SUM_E0 = 32'(j) * xtb_pkg::DELTA_POS;
        localparam logic [31:0] SUM_E1 = 32'(j + 1) * xtb_pkg::DELTA_POS;
        localparam logic [31:0] SUM_D0 = 32'(CYCLE_COUNT - j) * xtb_pkg::DELTA_POS;
        localparam logic [31:0] SUM_D1 = 32'(CYCLE_COUNT - j - 1) * xtb_pkg::DELTA_POS;

        xtb_round #(
            .IS_ODD  (1'b0),
            .SUM_ENC (SUM_E0),
            .SUM_DEC (SUM_D0)
        ) u_even (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_key   (r_key),
            .i_stage (w_stage[2*j]),
            .o_stage (w_stage[2*j+1])
        );

        xtb_round #(
            .IS_ODD  (1'b1),
            .SUM_ENC (SUM_E1),
            .SUM_DEC (SUM_D1)
        ) u_odd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_key   (r_key),
            .i_stage (w_stage[2*j+1]),
            .o_stage (w_stage[2*j+2])
        );
    end

    // Undo the decrypt swap
    always_comb begin
        w_res.left  = w_stage[STAGES].dec ? w_stage[STAGES].b : w_stage[STAGES].a;
        w_res.right = w_stage[STAGES].dec ? w_stage[STAGES].a : w_stage[STAGES].b;
    end

    xtb_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_en && w_stage[STAGES].valid),
        .i_data  (w_res),
        .o_room  (w_en),
        .o_valid (out_ch.valid),
        .i_ready (out_ch.ready),
        .o_data  (w_out)
    );

    assign out_ch.out_left  = w_out.left;
    assign out_ch.out_right = w_out.right;

    // Accepted word occupies the first stage next cycle
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> w_stage[1].valid)
        else $error("accepted word missing from first stage");

    // A held pipeline keeps its last stage unchanged
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_stage[STAGES].valid) && $stable(w_stage[STAGES].a)
                  && $stable(w_stage[STAGES].b))
        else $error("last stage changed while stalled");

    // A finished word reaches the output buffer
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_stage[STAGES].valid) |=> out_ch.valid)
        else $error("finished word not presented");

endmodule

// ===== hdl/xtb_round.sv =====
// One Feistel half-round with its pipeline register.
module xtb_round #(
    parameter bit          IS_ODD  = 1'b0,
    parameter logic [31:0] SUM_ENC = 32'h0000_0000,
    parameter logic [31:0] SUM_DEC = 32'h0000_0000
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  xtb_pkg::t_key  i_key,
    input  xtb_pkg::t_stage i_stage,
    output xtb_pkg::t_stage o_stage
);

    // Key index is fixed per stage and direction: low sum bits on the v0
    // update, sum bits 12:11 on the v1 update.
    localparam logic [1:0] KSEL_ENC = IS_ODD ? SUM_ENC[12:11] : SUM_ENC[1:0];
    localparam logic [1:0] KSEL_DEC = IS_ODD ? SUM_DEC[1:0]   : SUM_DEC[12:11];

    xtb_pkg::t_word  w_src;
    xtb_pkg::t_word  w_dst;
    xtb_pkg::t_word  w_sum;
    xtb_pkg::t_word  w_key;
    xtb_pkg::t_word  w_f;
    xtb_pkg::t_word  w_new;
    xtb_pkg::t_stage n_stage;
    xtb_pkg::t_stage r_stage;

    always_comb begin
        w_src = IS_ODD ? i_stage.a : i_stage.b;
        w_dst = IS_ODD ? i_stage.b : i_stage.a;
        w_sum = i_stage.dec ? SUM_DEC : SUM_ENC;
        w_key = i_stage.dec ? i_key[KSEL_DEC] : i_key[KSEL_ENC];
        w_f   = xtb_pkg::mix(w_src) ^ (w_sum + w_key);
        w_new = i_stage.dec ? (w_dst - w_f) : (w_dst + w_f);
        n_stage = i_stage;
        if (IS_ODD) begin
            n_stage.b = w_new;
        end else begin
            n_stage.a = w_new;
        end
    end

    // Only the valid bit is reset; data just follows the enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.dec <= n_stage.dec;
            r_stage.a   <= n_stage.a;
            r_stage.b   <= n_stage.b;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/xtb_out_fifo.sv =====
// Two-entry output buffer. Pipeline may advance only while it has room.
module xtb_out_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xtb_pkg::t_block i_data,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output xtb_pkg::t_block o_data
);

    xtb_pkg::t_block r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic            w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule
